// File: sv/wpm_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher package
// Shared types, byte codes and the letter folding function.
// ----------------------------------------------------------------------------
package wpm_pkg;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_TEXT   = 2'd1,
    MODE_END    = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef struct packed {
    logic text_step;
    logic rearm;
  } cell_ctrl_t;

  localparam logic [7:0] STAR_BYTE    = 8'h2A;
  localparam logic [7:0] ANY_BYTE     = 8'h3F;
  localparam logic [7:0] LOWER_FIRST  = 8'h61;
  localparam logic [7:0] LOWER_LAST   = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic case_sens);
    logic [7:0] r;
    r = b;
    if (!case_sens && (b >= LOWER_FIRST) && (b <= LOWER_LAST)) begin
      r = b - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// File: sv/wpm_cell.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher cell
// Holds one pattern byte and the active bit of its position, and passes the
// star closure and the advance bit on to the next cell.
// ----------------------------------------------------------------------------
module wpm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  wpm_pkg::cell_ctrl_t ctrl,
  input  logic               home,
  input  logic               valid,
  input  logic               wr_en,
  input  logic [7:0]         wr_byte,
  input  logic [7:0]         text_byte,
  input  logic               case_sensitive,
  input  logic               carry_in,
  input  logic               adv_in,
  output logic               cur_out,
  output logic               carry_out,
  output logic               adv_out
);

  logic [7:0] byte_r, byte_nxt;
  logic       active_r, active_nxt;
  logic       live, is_star, hit;

  assign is_star = (byte_r == wpm_pkg::STAR_BYTE);
  assign hit     = (byte_r == wpm_pkg::ANY_BYTE) ||
                   (wpm_pkg::fold_byte(byte_r, case_sensitive) ==
                    wpm_pkg::fold_byte(text_byte, case_sensitive));
  assign cur_out   = active_r | carry_in;
  assign live      = cur_out & valid;
  assign carry_out = live & is_star;
  assign adv_out   = live & !is_star & hit;

  always_comb begin
    active_nxt = active_r;
    if (ctrl.rearm) begin
      active_nxt = home;
    end else if (ctrl.text_step) begin
      active_nxt = carry_out | adv_in;
    end
    byte_nxt = wr_en ? wr_byte : byte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= home;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

// File: sv/wildcard_pattern_matcher.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher
// Matches streamed text against a loaded pattern with star and question mark.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle in every mode while in_tready holds.
// An end-of-text result is registered in the output or the skid slot.
// The clock period is set by the star closure rippling through the cell row.
// Two result slots keep input flowing while one result waits downstream.
// Reset (synchronous, rst_n low) empties the pattern, arms position zero,
// clears the overflow flag, selects case folding and drops pending results.
module wildcard_pattern_matcher #(
  parameter int PATTERN_MAX = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // case_sensitive
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // ch
  input  logic [1:0] in_tuser,      // mode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata      // matched, pattern_overflow, zero fill
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  logic                 case_sens_r, case_sens_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 last_r, last_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_data_r, out_data_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  logic [1:0]           skid_data_r, skid_data_nxt;

  wpm_pkg::mode_t       mode;
  wpm_pkg::cell_ctrl_t  ctrl;
  logic                 in_fire, append, full, end_fire, out_take;
  logic [PATTERN_MAX:0] carry, adv, cur;
  logic [1:0]           result;

  assign mode      = wpm_pkg::mode_t'(in_tuser);
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid & in_tready;
  assign append    = in_fire && (mode == wpm_pkg::MODE_APPEND);
  assign end_fire  = in_fire && (mode == wpm_pkg::MODE_END);
  assign full      = (len_r == LEN_W'(PATTERN_MAX));

  assign ctrl.text_step = in_fire && (mode == wpm_pkg::MODE_TEXT);
  assign ctrl.rearm     = in_fire && ((mode == wpm_pkg::MODE_END) ||
                                      (mode == wpm_pkg::MODE_CLEAR));

  assign carry[0] = 1'b0;
  assign adv[0]   = 1'b0;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    wpm_cell u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctrl           (ctrl),
      .home           (i == 0),
      .valid          (len_r > LEN_W'(i)),
      .wr_en          (append && (len_r == LEN_W'(i))),
      .wr_byte        (in_tdata),
      .text_byte      (in_tdata),
      .case_sensitive (case_sens_r),
      .carry_in       (carry[i]),
      .adv_in         (adv[i]),
      .cur_out        (cur[i]),
      .carry_out      (carry[i+1]),
      .adv_out        (adv[i+1])
    );
  end

  assign cur[PATTERN_MAX] = last_r | carry[PATTERN_MAX];
  assign result           = {ovf_r, cur[len_r]};
  assign out_take         = out_valid_r & out_tready;

  always_comb begin
    case_sens_nxt = cfg_wr_en ? cfg_wr_data : case_sens_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    if (ctrl.rearm) begin
      last_nxt = 1'b0;
    end else if (ctrl.text_step) begin
      last_nxt = adv[PATTERN_MAX];
    end
    if (in_fire && (mode == wpm_pkg::MODE_CLEAR)) begin
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (append) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        len_nxt = len_r + LEN_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_take && skid_valid_r) begin
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end else if (out_take || !out_valid_r) begin
      out_valid_nxt = end_fire;
      if (end_fire) begin
        out_data_nxt = result;
      end
    end else if (end_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_sens_r  <= 1'b0;
      len_r        <= '0;
      ovf_r        <= 1'b0;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      case_sens_r  <= case_sens_nxt;
      len_r        <= len_nxt;
      ovf_r        <= ovf_nxt;
      last_r       <= last_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r};

  a_len_bound : assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(PATTERN_MAX))
    else $error("pattern length beyond store size");

  a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot filled while output slot empty");

  a_end_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    end_fire |=> out_valid_r)
    else $error("end-of-text transaction produced no result");

  a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (mode == wpm_pkg::MODE_CLEAR)) |=> (len_r == '0) && !ovf_r)
    else $error("clear did not empty the pattern");

  a_overflow_only_full : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> (len_r == LEN_W'(PATTERN_MAX)))
    else $error("overflow flagged with room left in the store");

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher testbench
// Loads patterns with stars and question marks, streams texts under both case
// settings and checks each verdict against a bit-parallel position predictor or the opening plan.
// ----------------------------------------------------------------------------
module tb;

  localparam int PATTERN_MAX = 32;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 90;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic ovf;
    logic matched;
  } verdict_t;

  typedef struct packed {
    wpm_pkg::mode_t m;
    logic [7:0]     ch;
    logic           typed;
    verdict_t       want;
  } plan_row_t;

  localparam plan_row_t OPENING_PLAN [25] = '{
    '{wpm_pkg::MODE_END,    8'h00,              1'b1, '{1'b0, 1'b1}},
    '{wpm_pkg::MODE_TEXT,   8'h61,              1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_END,    8'h00,              1'b1, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_APPEND, wpm_pkg::STAR_BYTE, 1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_TEXT,   8'hFF,              1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_TEXT,   8'h00,              1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_END,    8'hFF,              1'b1, '{1'b0, 1'b1}},
    '{wpm_pkg::MODE_CLEAR,  8'hFF,              1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_APPEND, 8'h61,              1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_APPEND, wpm_pkg::ANY_BYTE,  1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_APPEND, 8'h00,              1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_TEXT,   8'h41,              1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_TEXT,   wpm_pkg::STAR_BYTE, 1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_TEXT,   8'h00,              1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_END,    8'h00,              1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_TEXT,   8'h61,              1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_TEXT,   wpm_pkg::ANY_BYTE,  1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_APPEND, wpm_pkg::STAR_BYTE, 1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_TEXT,   8'h00,              1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_TEXT,   8'h80,              1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_END,    8'h00,              1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_TEXT,   8'h61,              1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_END,    8'h00,              1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_CLEAR,  8'h00,              1'b0, '{1'b0, 1'b0}},
    '{wpm_pkg::MODE_END,    8'h00,              1'b1, '{1'b0, 1'b1}}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;  // ch
  logic [1:0] in_tuser = 2'd0;   // mode
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // matched, pattern_overflow, zero fill

  logic [7:0]  pat_store [PATTERN_MAX];
  int          pat_len = 0;
  logic [32:0] live_pos = 33'd1;
  logic        ovf_seen = 1'b0;
  logic        exact_case = 1'b0;

  verdict_t verdicts_due [$];
  int       errors = 0;
  int       items_sent = 0;
  bit       steady = 1'b0;
  int       holds_asked = 0;
  int       holds_served = 0;
  int       hold_left = 0;

  wildcard_pattern_matcher #(.PATTERN_MAX(PATTERN_MAX)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic logic [7:0] fold_letter(input logic [7:0] b);
    if (!exact_case && b >= wpm_pkg::LOWER_FIRST && b <= wpm_pkg::LOWER_LAST) begin
      return b - wpm_pkg::CASE_OFFSET;
    end
    return b;
  endfunction

  function automatic logic [32:0] close_stars(input logic [32:0] s);
    logic [32:0] r;
    r = s;
    for (int i = 0; i < pat_len; i++) begin
      if (r[i] && pat_store[i] == wpm_pkg::STAR_BYTE) begin
        r[i + 1] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [32:0] step_positions(input logic [32:0] s,
                                                 input logic [7:0] b);
    logic [32:0] cur;
    logic [32:0] nxt;
    cur = close_stars(s);
    nxt = '0;
    for (int i = 0; i < pat_len; i++) begin
      if (cur[i]) begin
        if (pat_store[i] == wpm_pkg::STAR_BYTE) begin
          nxt[i] = 1'b1;
        end else if (pat_store[i] == wpm_pkg::ANY_BYTE ||
                     fold_letter(pat_store[i]) == fold_letter(b)) begin
          nxt[i + 1] = 1'b1;
        end
      end
    end
    return nxt;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] letters [4];
    letters = '{8'h61, 8'h41, 8'h62, 8'h42};
    if ($urandom_range(0, 99) < 75) begin
      return letters[$urandom_range(0, 3)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pattern_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      return wpm_pkg::STAR_BYTE;
    end else if (r < 35) begin
      return wpm_pkg::ANY_BYTE;
    end
    return text_byte();
  endfunction

  task automatic send_item(input wpm_pkg::mode_t m, input logic [7:0] ch,
                           input logic typed, input verdict_t want);
    verdict_t v;
    logic [32:0] cur;
    if (!steady && $urandom_range(0, 99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= m;
    in_tdata <= ch;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    case (m)
      wpm_pkg::MODE_APPEND: begin
        if (pat_len < PATTERN_MAX) begin
          pat_store[pat_len] = ch;
          pat_len++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      wpm_pkg::MODE_TEXT: begin
        live_pos = step_positions(live_pos, ch);
      end
      wpm_pkg::MODE_END: begin
        cur = close_stars(live_pos);
        v.matched = cur[pat_len];
        v.ovf = ovf_seen;
        live_pos = 33'd1;
        verdicts_due = {verdicts_due, (typed ? want : v)};
      end
      default: begin
        pat_len = 0;
        ovf_seen = 1'b0;
        live_pos = 33'd1;
      end
    endcase
  endtask

  task automatic write_case_mode(input logic value);
    in_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    exact_case = value;
  endtask

  task automatic run_episode();
    logic [7:0] txt [$];
    logic [7:0] b;
    int n;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        send_item(wpm_pkg::mode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'b0, '0);
      end
      return;
    end
    if ($urandom_range(0, 4) != 0) begin
      send_item(wpm_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '0);
    end
    n = ($urandom_range(0, 99) < 8) ? $urandom_range(30, 40) : $urandom_range(0, 8);
    repeat (n) send_item(wpm_pkg::MODE_APPEND, pattern_byte(), 1'b0, '0);
    repeat ($urandom_range(1, 4)) begin
      txt.delete();
      if ($urandom_range(0, 99) < 60) begin
        for (int i = 0; i < pat_len; i++) begin
          if (pat_store[i] == wpm_pkg::STAR_BYTE) begin
            repeat ($urandom_range(0, 2)) txt = {txt, text_byte()};
          end else if (pat_store[i] == wpm_pkg::ANY_BYTE) begin
            txt = {txt, 8'($urandom_range(0, 255))};
          end else begin
            b = pat_store[i];
            if ($urandom_range(0, 1) == 1 && (b | wpm_pkg::CASE_OFFSET) >= wpm_pkg::LOWER_FIRST
                && (b | wpm_pkg::CASE_OFFSET) <= wpm_pkg::LOWER_LAST) begin
              b = b ^ wpm_pkg::CASE_OFFSET;
            end
            txt = {txt, b};
          end
        end
        if (txt.size() != 0 && $urandom_range(0, 99) < 15) begin
          txt[$urandom_range(0, txt.size() - 1)] = text_byte();
        end
      end else begin
        repeat ($urandom_range(0, 10)) txt = {txt, text_byte()};
      end
      foreach (txt[k]) begin
        if ($urandom_range(0, 99) < 3) begin
          send_item(wpm_pkg::MODE_APPEND, pattern_byte(), 1'b0, '0);
        end
        send_item(wpm_pkg::MODE_TEXT, txt[k], 1'b0, '0);
      end
      send_item(wpm_pkg::MODE_END, 8'($urandom_range(0, 255)), 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts_due.size() == 0) begin
        report_mismatch("unexpected result, out_tdata", int'(out_tdata), 0);
      end else begin
        want = verdicts_due.pop_front();
        if (out_tdata[0] !== want.matched) begin
          report_mismatch("matched", int'(out_tdata[0]), int'(want.matched));
        end
        if (out_tdata[1] !== want.ovf) begin
          report_mismatch("pattern_overflow", int'(out_tdata[1]), int'(want.ovf));
        end
        if (out_tdata[7:2] !== 6'd0) begin
          report_mismatch("zero fill", int'(out_tdata[7:2]), 0);
        end
      end
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_tready <= 1'b0;
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= 7);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_case_mode(1'b0);
    foreach (OPENING_PLAN[r]) begin
      send_item(OPENING_PLAN[r].m, OPENING_PLAN[r].ch, OPENING_PLAN[r].typed,
                OPENING_PLAN[r].want);
    end
    for (int p = 0; p < PHASES; p++) begin
      write_case_mode(p % 2 == 0);
      steady = (p == 4);
      if (p == 2) begin
        holds_asked++;
      end
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) run_episode();
    end
    in_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("wildcard_pattern_matcher verification clean");
    end else begin
      $display("wildcard_pattern_matcher verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("wildcard_pattern_matcher verification failed");
    $finish;
  end

endmodule
